>>> rtl/wsma_pkg.sv
// ----------------------------------------------------------------------------
// wsma_pkg
// Types and constants shared by the word-serial modular adder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsma_pkg;

  localparam int unsigned FieldBits = 8;
  localparam int unsigned ModBits   = 32;

  localparam logic [ModBits-1:0] ModulusReset = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [FieldBits-1:0] a_word;
    logic [FieldBits-1:0] b_word;
  } in_beat_t;

  typedef struct packed {
    logic [FieldBits-1:0] result_word;
    logic                 last_word;
  } out_beat_t;

  typedef enum logic {
    PH_COLLECT,
    PH_EMIT
  } phase_e;

endpackage

`default_nettype wire

>>> rtl/wsma_word_add.sv
// ----------------------------------------------------------------------------
// wsma_word_add
// One word step: a + b + carry, and in parallel sum word - p word - borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module wsma_word_add #(
  parameter int unsigned WORD_BITS = 8
) (
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  input  wire logic [WORD_BITS-1:0] p_i,
  input  wire logic                 carry_i,
  input  wire logic                 borrow_i,
  output logic      [WORD_BITS-1:0] sum_o,
  output logic      [WORD_BITS-1:0] diff_o,
  output logic                      carry_o,
  output logic                      borrow_o
);

  logic [WORD_BITS:0] add_full;
  logic [WORD_BITS:0] sub_full;

  assign add_full = {1'b0, a_i} + {1'b0, b_i} + {{WORD_BITS{1'b0}}, carry_i};
  assign sum_o    = add_full[WORD_BITS-1:0];
  assign carry_o  = add_full[WORD_BITS];

  // top bit of the (W+1)-bit difference is the borrow out
  assign sub_full = {1'b0, sum_o} - {1'b0, p_i} - {{WORD_BITS{1'b0}}, borrow_i};
  assign diff_o   = sub_full[WORD_BITS-1:0];
  assign borrow_o = sub_full[WORD_BITS];

endmodule

`default_nettype wire

>>> rtl/wsma_cell.sv
// ----------------------------------------------------------------------------
// wsma_cell
// One cell of the word chain: holds a sum word and a difference word and
// passes them to its lower neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wsma_cell #(
  parameter int unsigned WORD_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 shift_i,
  input  wire logic [WORD_BITS-1:0] sum_i,
  input  wire logic [WORD_BITS-1:0] diff_i,
  output logic      [WORD_BITS-1:0] sum_o,
  output logic      [WORD_BITS-1:0] diff_o
);

  logic [WORD_BITS-1:0] sum_q;
  logic [WORD_BITS-1:0] diff_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q  <= sum_i;
      diff_q <= diff_i;
    end
  end

  assign sum_o  = sum_q;
  assign diff_o = diff_q;

endmodule

`default_nettype wire

>>> rtl/word_serial_modular_adder.sv
// ----------------------------------------------------------------------------
// word_serial_modular_adder
// Word-serial (a + b) mod p over WORDS words of WORD_BITS bits.
// ----------------------------------------------------------------------------
// Operand word pairs enter least significant first, one beat per cycle.
// Each pair is added with the running carry while the matching modulus word
// is subtracted with the running borrow; both words move into a row of
// WORDS cells. After the last pair the row shifts out WORDS result beats,
// least significant first, last_word on the final one: the difference when
// the sum is at least p, else the sum. The cell row serves both intake and
// readout, so no input is taken during readout. Inputs are expected below p;
// only one conditional subtraction is made. Write modulus only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module word_serial_modular_adder #(
  parameter int unsigned WORD_BITS = 8,
  parameter int unsigned WORDS     = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     modulus_we_i,
  input  wire logic [31:0]              modulus_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire wsma_pkg::in_beat_t       in_beat_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output wsma_pkg::out_beat_t           out_beat_o
);

  import wsma_pkg::*;

  localparam int unsigned IdxBits = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(WORDS - 1);
  localparam int unsigned PadBits = WORDS * WORD_BITS + ModBits;

  logic [ModBits-1:0] modulus_q;
  phase_e             phase_q, phase_d;
  logic [IdxBits-1:0] cnt_q, cnt_d;
  logic               carry_q, carry_d;
  logic               borrow_q, borrow_d;
  logic               take_diff_q, take_diff_d;

  logic in_acc, out_acc, shift;

  logic [WORD_BITS+FieldBits-1:0] a_pad, b_pad;
  logic [WORD_BITS-1:0]           a_w, b_w, p_w;
  logic [PadBits-1:0]             mod_pad;
  logic [WORD_BITS-1:0]           new_sum, new_diff;
  logic                           new_carry, new_borrow;

  logic [WORD_BITS-1:0] sum_chain  [WORDS+1];
  logic [WORD_BITS-1:0] diff_chain [WORDS+1];
  logic [WORD_BITS-1:0] head_w;
  logic [WORD_BITS+FieldBits-1:0] head_pad;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign shift   = in_acc || out_acc;

  assign a_pad   = {{WORD_BITS{1'b0}}, in_beat_i.a_word};
  assign b_pad   = {{WORD_BITS{1'b0}}, in_beat_i.b_word};
  assign a_w     = a_pad[WORD_BITS-1:0];
  assign b_w     = b_pad[WORD_BITS-1:0];
  assign mod_pad = {{(WORDS * WORD_BITS){1'b0}}, modulus_q};
  assign p_w     = mod_pad[cnt_q * WORD_BITS +: WORD_BITS];

  wsma_word_add #(
    .WORD_BITS (WORD_BITS)
  ) u_word_add (
    .a_i      (a_w),
    .b_i      (b_w),
    .p_i      (p_w),
    .carry_i  (carry_q),
    .borrow_i (borrow_q),
    .sum_o    (new_sum),
    .diff_o   (new_diff),
    .carry_o  (new_carry),
    .borrow_o (new_borrow)
  );

  // new words enter at the top cell and walk down toward cell 0
  assign sum_chain[WORDS]  = new_sum;
  assign diff_chain[WORDS] = new_diff;

  for (genvar k = 0; k < WORDS; k++) begin : g_cell
    wsma_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .sum_i   (sum_chain[k+1]),
      .diff_i  (diff_chain[k+1]),
      .sum_o   (sum_chain[k]),
      .diff_o  (diff_chain[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COLLECT;
      cnt_q       <= '0;
      carry_q     <= 1'b0;
      borrow_q    <= 1'b0;
      take_diff_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      carry_q     <= carry_d;
      borrow_q    <= borrow_d;
      take_diff_q <= take_diff_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    carry_d     = carry_q;
    borrow_d    = borrow_q;
    take_diff_d = take_diff_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (phase_q)
      PH_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q == LastIdx) begin
            take_diff_d = new_carry || !new_borrow;
            carry_d     = 1'b0;
            borrow_d    = 1'b0;
            cnt_d       = '0;
            phase_d     = PH_EMIT;
          end else begin
            carry_d  = new_carry;
            borrow_d = new_borrow;
            cnt_d    = cnt_q + 1'b1;
          end
        end
      end
      PH_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            phase_d = PH_COLLECT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_COLLECT;
      end
    endcase
  end

  assign head_w   = take_diff_q ? diff_chain[0] : sum_chain[0];
  assign head_pad = {{FieldBits{1'b0}}, head_w};

  assign out_beat_o.result_word = head_pad[FieldBits-1:0];
  assign out_beat_o.last_word   = (cnt_q == LastIdx);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output phases overlap");

  a_final_in_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_q == LastIdx) |=> (out_valid_o && cnt_q == '0))
    else $error("readout did not start after final word");

  a_mid_in_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_q != LastIdx) |=> !out_valid_o)
    else $error("result beat before operand complete");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_beat_o.last_word) |=> (!out_valid_o && !carry_q && !borrow_q))
    else $error("readout did not end after last word");
`endif

endmodule

`default_nettype wire

>>> tb/tb_word_serial_modular_adder.sv
// ----------------------------------------------------------------------------
// tb_word_serial_modular_adder
// Self-checking testbench for the word-serial modular adder.
// ----------------------------------------------------------------------------
// Operands go in as four word-pair beats, least significant first. A local
// model keeps its own carry, borrow, sum and difference words and the modulus
// value, and queues the four result beats due after each last word pair.
// Every output beat is checked against that queue. Directed operands cover
// sums just below, at and above p, carry out of the top word and the modulus
// extremes. Random operands then run under several moduli, with random
// sender gaps and receiver stalls and stretches without either.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_word_serial_modular_adder;
  import wsma_pkg::*;

  localparam int unsigned WordBits   = 8;
  localparam int unsigned Words      = 4;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 3 * Words;

  logic      clk_i;
  logic      rst_ni;
  logic      modulus_we_i;
  logic [31:0] modulus_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_beat_o;

  word_serial_modular_adder #(
    .WORD_BITS(WordBits),
    .WORDS    (Words)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_we_i(modulus_we_i),
    .modulus_i   (modulus_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // model state
  logic [31:0]         modulus_q;
  int unsigned         acc_idx;
  logic                acc_carry;
  logic                acc_borrow;
  logic [WordBits-1:0] sum_words  [Words];
  logic [WordBits-1:0] diff_words [Words];
  out_beat_t           expected_words[$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned rx_beats;
  bit          tx_idle_on;
  bit          rx_idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void accumulate_word_pair(logic [WordBits-1:0] a, logic [WordBits-1:0] b);
    logic [WordBits:0]   s;
    logic [WordBits:0]   sub;
    logic [WordBits-1:0] sw;
    logic [31:0]         p_shifted;
    logic                take_diff;
    out_beat_t           beat;
    s          = {1'b0, a} + {1'b0, b} + {{WordBits{1'b0}}, acc_carry};
    sw         = s[WordBits-1:0];
    acc_carry  = s[WordBits];
    p_shifted  = modulus_q >> (WordBits * acc_idx);
    sub        = {1'b0, p_shifted[WordBits-1:0]} + {{WordBits{1'b0}}, acc_borrow};
    sum_words[acc_idx]  = sw;
    diff_words[acc_idx] = sw - sub[WordBits-1:0];
    acc_borrow = ({1'b0, sw} < sub);
    if (acc_idx == Words - 1) begin
      take_diff = acc_carry || !acc_borrow;
      for (int k = 0; k < Words; k++) begin
        beat.result_word = take_diff ? diff_words[k] : sum_words[k];
        beat.last_word   = (k == Words - 1);
        expected_words.push_back(beat);
      end
      acc_idx    = 0;
      acc_carry  = 1'b0;
      acc_borrow = 1'b0;
    end else begin
      acc_idx++;
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_word_pair(logic [WordBits-1:0] a, logic [WordBits-1:0] b);
    int unsigned gap;
    in_beat_t    beat;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    beat.a_word = a;
    beat.b_word = b;
    in_beat_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_word_pair(a, b);
    @(negedge clk_i);
  endtask

  task automatic send_operand(logic [31:0] a, logic [31:0] b);
    for (int i = 0; i < Words; i++) begin
      send_word_pair(a[WordBits*i +: WordBits], b[WordBits*i +: WordBits]);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_modulus(logic [31:0] value);
    drain_results();
    modulus_we_i <= 1'b1;
    modulus_i    <= value;
    @(negedge clk_i);
    modulus_we_i <= 1'b0;
    modulus_q     = value;
  endtask

  function automatic logic [31:0] draw_below(logic [31:0] p);
    logic [31:0] r;
    r = $urandom;
    return (p == 0) ? r : r % p;
  endfunction

  task automatic send_random_operand();
    logic [31:0] a;
    logic [31:0] b;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    a    = draw_below(modulus_q);
    b    = draw_below(modulus_q);
    case (kind)
      6: begin
        b = modulus_q - a;
      end
      7: begin
        b = modulus_q - 1 - a;
      end
      8, 9: begin
        a = $urandom;
        b = $urandom;
      end
      default: ;
    endcase
    send_operand(a, b);
  endtask

  task automatic test_reset_modulus();
    tx_idle_on = 1'b1;
    send_operand(32'h0000_0000, 32'h0000_0000);
    send_operand(32'h7FFF_FFFE, 32'h7FFF_FFFE);
    send_operand(32'h0000_0001, 32'h7FFF_FFFE);
    send_operand(32'h0000_0000, 32'h7FFF_FFFE);
  endtask

  task automatic test_modulus_extremes();
    set_modulus(32'hFFFF_FFFF);
    send_operand(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    set_modulus(32'h0000_0000);
    send_operand(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_drain_pause();
    set_modulus(32'hFFFF_FFFB);
    for (int i = 0; i < 3; i++) begin
      send_random_operand();
      drain_results();
    end
  endtask

  task automatic test_random_moduli();
    logic [31:0] moduli [5];
    moduli[0] = $urandom;
    moduli[1] = $urandom_range(1, 255);
    moduli[2] = $urandom | 32'h8000_0000;
    moduli[3] = 32'h0000_0001;
    moduli[4] = wsma_pkg::ModulusReset;
    for (int ph = 0; ph < 5; ph++) begin
      set_modulus(moduli[ph]);
      tx_idle_on = 1'($urandom_range(0, 1));
      for (int i = 0; i < 17; i++) begin
        if ($urandom_range(0, 5) == 0) tx_idle_on = !tx_idle_on;
        send_random_operand();
      end
    end
  endtask

  task automatic check_result(out_beat_t got);
    out_beat_t want;
    if (expected_words.size() == 0) begin
      $error("result_word: unexpected beat, got %0h last_word %0b",
             got.result_word, got.last_word);
      error_count++;
    end else begin
      want = expected_words.pop_front();
      if (got.result_word !== want.result_word) begin
        $error("result_word: expected %0h, got %0h", want.result_word, got.result_word);
        error_count++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
        error_count++;
      end
    end
  endtask

  // result side
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    rx_beats    = 0;
    rx_idle_on  = 1'b1;
    @(negedge clk_i);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_beat_o);
      rx_beats++;
      if (rx_beats % 24 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    modulus_we_i = 1'b0;
    modulus_i    = '0;
    in_valid_i   = 1'b0;
    in_beat_i    = '0;
    idle_cycles  = 0;
    error_count  = 0;
    tx_idle_on   = 1'b1;
    modulus_q    = wsma_pkg::ModulusReset;
    acc_idx      = 0;
    acc_carry    = 1'b0;
    acc_borrow   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_modulus();
    test_modulus_extremes();
    test_drain_pause();
    test_random_moduli();

    drain_results();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
